// ----- hdl/dq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Holds command and status codes, field widths and controller/datapath structs.
// No dependencies.
package dq_pkg;

	localparam int DATA_W    = 32;
	localparam int CMD_W     = 4;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 7;
	localparam int DEPTH_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 4'd4;
	localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_SIZE       = 4'd6;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd7;
	localparam logic [CMD_W-1:0] CMD_DUMP       = 4'd8;
	localparam logic [CMD_W-1:0] CMD_DUMP_REV   = 4'd9;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		VAL_DATA,
		VAL_ZERO,
		VAL_COUNT
	} val_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic                ins_front;
		logic                ins_back;
		logic                rem_front;
		logic                rem_back;
		logic                clear;
		logic                rd_front;
		logic                rd_back;
		logic                rd_dump;
		logic                dump_start;
		logic                dump_rev;
		logic                dump_next;
		logic                ld_res;
		logic                ld_ram;
		val_sel_t            val_sel;
		logic [STATUS_W-1:0] res_status;
		logic                res_last;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic dump_last;
	} sts_t;

endpackage

// ----- hdl/dq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/dq_datapath.sv -----
// Datapath of the double-ended queue: head and count registers, circular
// address math, element RAM and the result register.
// Depends on dq_pkg and dq_ram.
module dq_datapath #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dq_pkg::ctl_t                  ctl,
	output dq_pkg::sts_t                  sts,
	input  logic signed [dq_pkg::DATA_W-1:0]   data_in,
	output logic signed [dq_pkg::DATA_W-1:0]   value_out,
	output logic [dq_pkg::STATUS_W-1:0]   status,
	output logic [dq_pkg::COUNT_W-1:0]    count_out,
	output logic                          last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic          rev_q;

	logic [dq_pkg::DATA_W-1:0]   value_q;
	logic [dq_pkg::STATUS_W-1:0] status_q;
	logic                        last_q;

	logic [IW-1:0] head_dec;
	logic [IW-1:0] head_inc;
	logic [IW-1:0] back_off;
	logic [IW-1:0] dump_idx;
	logic          dump_rev;
	logic [IW-1:0] dump_off;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic          re;
	logic          we;
	logic [dq_pkg::DATA_W-1:0] rdata;
	logic [dq_pkg::DATA_W-1:0] imm_val;

	// head + offset, wrapped into the store
	function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
			input logic [IW-1:0] off);
		logic [IW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IW+1)'(DEPTH)) begin
			sum = sum - (IW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign head_dec = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
	assign head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
	assign back_off = IW'(count_q - CW'(1));

	// next dump position: restart at zero or step forward
	assign dump_idx = ctl.dump_start ? '0 : (idx_q + IW'(ctl.dump_next));
	assign dump_rev = ctl.dump_start ? ctl.dump_rev : rev_q;
	assign dump_off = dump_rev ? IW'(count_q - CW'(1) - CW'(dump_idx)) : dump_idx;

	always_comb begin
		raddr = head_q;
		if (ctl.rd_back) begin
			raddr = slot(head_q, back_off);
		end else if (ctl.rd_dump) begin
			raddr = slot(head_q, dump_off);
		end
	end

	assign re    = ctl.rd_front | ctl.rd_back | ctl.rd_dump;
	assign we    = ctl.ins_front | ctl.ins_back;
	assign waddr = ctl.ins_front ? head_dec : slot(head_q, IW'(count_q));

	dq_ram #(
		.WIDTH(dq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(data_in),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			rev_q   <= 1'b0;
		end else begin
			if (ctl.clear) begin
				head_q  <= '0;
				count_q <= '0;
			end else if (ctl.ins_front) begin
				head_q  <= head_dec;
				count_q <= count_q + CW'(1);
			end else if (ctl.ins_back) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.rem_front) begin
				head_q  <= head_inc;
				count_q <= count_q - CW'(1);
			end else if (ctl.rem_back) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.dump_start || ctl.dump_next) begin
				idx_q <= dump_idx;
				rev_q <= dump_rev;
			end
		end
	end

	always_comb begin
		case (ctl.val_sel)
			dq_pkg::VAL_DATA:  imm_val = data_in;
			dq_pkg::VAL_COUNT: imm_val = dq_pkg::DATA_W'(count_q);
			default:           imm_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_res) begin
			value_q  <= imm_val;
			status_q <= ctl.res_status;
			last_q   <= ctl.res_last;
		end else if (ctl.ld_ram) begin
			value_q  <= rdata;
			status_q <= dq_pkg::ST_OK;
			last_q   <= ctl.res_last;
		end
	end

	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.dump_last = (CW'(idx_q) == count_q - CW'(1));

	assign value_out = value_q;
	assign status    = status_q;
	assign count_out = dq_pkg::COUNT_W'(count_q);
	assign last      = last_q;

endmodule

// ----- hdl/dq_ctrl.sv -----
// Controller of the double-ended queue: decodes requests and sequences
// RAM reads, result hand-off and dump iteration. Depends on dq_pkg.
module dq_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [dq_pkg::CMD_W-1:0] cmd,
	output logic                     out_valid,
	input  logic                     out_ready,
	output dq_pkg::ctl_t             ctl,
	input  dq_pkg::sts_t             sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   dump_q;
	logic   dump_nxt;
	logic   in_ready_q;
	logic   out_valid_q;

	// immediate result: loaded straight into the output register
	function automatic dq_pkg::ctl_t imm(input dq_pkg::ctl_t c, input dq_pkg::val_sel_t v,
			input logic [dq_pkg::STATUS_W-1:0] s);
		dq_pkg::ctl_t r;
		r            = c;
		r.ld_res     = 1'b1;
		r.val_sel    = v;
		r.res_status = s;
		r.res_last   = 1'b1;
		return r;
	endfunction

	always_comb begin
		ctl          = '0;
		ctl.val_sel  = dq_pkg::VAL_ZERO;
		state_nxt    = state_q;
		dump_nxt     = dump_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_OUT;
					case (cmd)
						dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
							if (sts.full) begin
								ctl = imm(ctl, dq_pkg::VAL_DATA, dq_pkg::ST_FULL);
							end else begin
								ctl = imm(ctl, dq_pkg::VAL_DATA, dq_pkg::ST_OK);
								ctl.ins_front = (cmd == dq_pkg::CMD_PUSH_FRONT);
								ctl.ins_back  = (cmd == dq_pkg::CMD_PUSH_BACK);
							end
						end
						dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_PEEK_FRONT: begin
							if (sts.empty) begin
								ctl = imm(ctl, dq_pkg::VAL_ZERO, dq_pkg::ST_EMPTY);
							end else begin
								ctl.rd_front  = 1'b1;
								ctl.rem_front = (cmd == dq_pkg::CMD_POP_FRONT);
								state_nxt     = S_READ;
							end
						end
						dq_pkg::CMD_POP_BACK, dq_pkg::CMD_PEEK_BACK: begin
							if (sts.empty) begin
								ctl = imm(ctl, dq_pkg::VAL_ZERO, dq_pkg::ST_EMPTY);
							end else begin
								ctl.rd_back  = 1'b1;
								ctl.rem_back = (cmd == dq_pkg::CMD_POP_BACK);
								state_nxt    = S_READ;
							end
						end
						dq_pkg::CMD_SIZE: begin
							ctl = imm(ctl, dq_pkg::VAL_COUNT, dq_pkg::ST_OK);
						end
						dq_pkg::CMD_CLEAR: begin
							ctl       = imm(ctl, dq_pkg::VAL_ZERO, dq_pkg::ST_EMPTY);
							ctl.clear = 1'b1;
						end
						dq_pkg::CMD_DUMP, dq_pkg::CMD_DUMP_REV: begin
							if (sts.empty) begin
								ctl = imm(ctl, dq_pkg::VAL_ZERO, dq_pkg::ST_EMPTY);
							end else begin
								ctl.dump_start = 1'b1;
								ctl.dump_rev   = (cmd == dq_pkg::CMD_DUMP_REV);
								ctl.rd_dump    = 1'b1;
								dump_nxt       = 1'b1;
								state_nxt      = S_READ;
							end
						end
						default: begin
							// unused code: drop without a result
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				ctl.ld_ram   = 1'b1;
				ctl.res_last = dump_q ? sts.dump_last : 1'b1;
				state_nxt    = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					if (dump_q && !sts.dump_last) begin
						ctl.dump_next = 1'b1;
						ctl.rd_dump   = 1'b1;
						state_nxt     = S_READ;
					end else begin
						dump_nxt  = 1'b0;
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dump_q      <= 1'b0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			dump_q      <= dump_nxt;
			in_ready_q  <= (state_nxt == S_IDLE);
			out_valid_q <= (state_nxt == S_OUT);
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/double_ended_queue.sv -----
// Top level of the double-ended queue of signed 32-bit values.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: cmd and data_in.
//   Output channel (out_valid/out_ready) carries results: value_out, status,
//   count_out and last. Every defined request gives one result, except dump and
//   dump reversed on a non-empty queue, which give one result per element
//   with last set on the final one. Unused cmd codes are taken and dropped.
//   Result path: push, size and clear load their result straight into the
//   result register; pop and peek pass first through the registered read
//   of the element RAM. A dump steps through S_READ and S_OUT for each
//   element while the receiver keeps out_ready high.
//   Throughput: one request at a time. in_ready returns in the cycle after
//   the last result of the previous request is taken; the single RAM read
//   port paces dumps.
//   Stall: while out_ready is low the result register holds and no new
//   request is taken.
//   Reset: arst_n clears head and count at once; the queue is empty and
//   ready for a request as soon as reset is released. The element RAM is
//   never cleared; only entries inside the count are ever read.
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dq_pkg::CMD_W-1:0]             cmd,
	input  logic signed [dq_pkg::DATA_W-1:0]     data_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [dq_pkg::DATA_W-1:0]     value_out,
	output logic [dq_pkg::STATUS_W-1:0]          status,
	output logic [dq_pkg::COUNT_W-1:0]           count_out,
	output logic                                 last
);

	// command and status links between controller and datapath
	dq_pkg::ctl_t ctl;
	dq_pkg::sts_t sts;

	// controller: decode request, sequence reads and dump steps
	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// datapath: hold head/count, address the RAM, hold the result
	dq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.data_in  (data_in),
		.value_out(value_out),
		.status   (status),
		.count_out(count_out),
		.last     (last)
	);

endmodule
